@@ rtl/psfp_pkg.sv @@
`default_nettype none

package psfp_pkg;

    localparam int BUFFER_BYTES = 64;
    // Payload positions never go past the 64-entry frame window.
    localparam int STORE_LIMIT  = (BUFFER_BYTES < 64) ? BUFFER_BYTES : 64;
    localparam int ADDR_W       = $clog2(STORE_LIMIT);
    localparam int POS_W        = 7;
    localparam int IDX_W        = 6;
    localparam int PAYLOAD_BASE = 3;

    typedef enum logic [1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_SYNC_THIRD  = 2'd2,
        CFG_FRAME_LEN   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] count;
    } t_run;

endpackage

`default_nettype wire

@@ rtl/psfp_store.sv @@
`default_nettype none

module psfp_store (
    input  wire logic                        i_clk,
    input  wire psfp_pkg::t_store_wr         i_wr,
    input  wire logic                        i_re,
    input  wire logic [psfp_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                       o_rdata
);

    logic [7:0] r_mem [psfp_pkg::STORE_LIMIT];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/psfp_parse.sv @@
`default_nettype none

module psfp_parse (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [7:0]            i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_byte,
    output psfp_pkg::t_store_wr        o_wr,
    output psfp_pkg::t_run             o_run
);

    typedef enum logic [4:0] {
        PH_SYNC1 = 5'b00001,
        PH_SYNC2 = 5'b00010,
        PH_SYNC3 = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_SUM   = 5'b10000
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [psfp_pkg::POS_W-1:0]   r_wp, n_wp;
    logic [7:0]                   r_sum, n_sum;
    logic [psfp_pkg::POS_W-1:0]   r_len, n_len;
    logic [7:0]                   r_sync1, r_sync2, r_sync3;
    logic [psfp_pkg::POS_W-1:0]   r_cfg_len;
    logic [psfp_pkg::POS_W:0]     w_next_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1   <= 8'd0;
            r_sync2   <= 8'd0;
            r_sync3   <= 8'd0;
            r_cfg_len <= psfp_pkg::POS_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psfp_pkg::CFG_SYNC_FIRST:  r_sync1   <= i_cfg_data;
                psfp_pkg::CFG_SYNC_SECOND: r_sync2   <= i_cfg_data;
                psfp_pkg::CFG_SYNC_THIRD:  r_sync3   <= i_cfg_data;
                psfp_pkg::CFG_FRAME_LEN:   r_cfg_len <= i_cfg_data[psfp_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Position after this byte, plus one for the checksum that follows.
    assign w_next_end = {1'b0, r_wp} + (psfp_pkg::POS_W+1)'(2);

    always_comb begin
        n_phase     = r_phase;
        n_wp        = r_wp;
        n_sum       = r_sum;
        n_len       = r_len;
        o_wr.we     = 1'b0;
        o_wr.addr   = r_wp[psfp_pkg::ADDR_W-1:0];
        o_wr.data   = i_byte;
        o_run.start = 1'b0;
        o_run.count = psfp_pkg::IDX_W'(r_wp - psfp_pkg::POS_W'(psfp_pkg::PAYLOAD_BASE));
        if (i_accept) begin
            case (r_phase)
                PH_SYNC2: begin
                    if (i_byte == r_sync2) begin
                        n_wp    = psfp_pkg::POS_W'(1);
                        n_len   = r_cfg_len;
                        n_sum   = 8'd0;
                        n_phase = PH_SYNC3;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_SYNC3: begin
                    if (i_byte == r_sync3) begin
                        n_wp    = psfp_pkg::POS_W'(psfp_pkg::PAYLOAD_BASE);
                        n_len   = r_cfg_len;
                        n_sum   = 8'd0;
                        n_phase = PH_DATA;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_DATA: begin
                    if (r_wp >= psfp_pkg::POS_W'(psfp_pkg::STORE_LIMIT - 1)) begin
                        // Store full while payload is still expected: drop the frame.
                        n_phase = PH_SYNC1;
                    end else begin
                        o_wr.we = 1'b1;
                        n_wp    = r_wp + psfp_pkg::POS_W'(1);
                        n_sum   = r_sum + i_byte;
                        if (w_next_end >= {1'b0, r_len}) begin
                            n_phase = PH_SUM;
                        end
                    end
                end
                PH_SUM: begin
                    if (i_byte == r_sum && r_wp > psfp_pkg::POS_W'(psfp_pkg::PAYLOAD_BASE)) begin
                        o_run.start = 1'b1;
                    end
                    n_phase = PH_SYNC1;
                end
                default: begin
                    n_wp    = '0;
                    n_sum   = 8'd0;
                    n_phase = (i_byte == r_sync1) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_wp    <= '0;
            r_sum   <= 8'd0;
            r_len   <= '0;
        end else begin
            r_phase <= n_phase;
            r_wp    <= n_wp;
            r_sum   <= n_sum;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

@@ rtl/psfp_emit.sv @@
`default_nettype none

module psfp_emit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire psfp_pkg::t_run              i_run,
    output logic                             o_re,
    output logic [psfp_pkg::ADDR_W-1:0]      o_raddr,
    input  wire logic [7:0]                  i_rdata,
    output logic                             o_busy,
    output logic                             o_tvalid,
    input  wire logic                        i_tready,
    output logic [15:0]                      o_tdata,
    output logic                             o_tlast
);

    logic [psfp_pkg::IDX_W-1:0]  r_left;
    logic [psfp_pkg::ADDR_W-1:0] r_ptr;
    logic [psfp_pkg::IDX_W-1:0]  r_k;
    logic                        r_rd_vld;
    logic [psfp_pkg::IDX_W-1:0]  r_rd_idx;
    logic                        r_rd_last;
    logic                        r_out_vld;
    logic [7:0]                  r_out_byte;
    logic [psfp_pkg::IDX_W-1:0]  r_out_idx;
    logic                        r_out_last;
    logic                        w_out_free;

    assign w_out_free = !r_out_vld || i_tready;
    // A read is issued only when the read-data stage is empty or passes its byte on to the output stage.
    assign o_re    = (r_left != '0) && (!r_rd_vld || w_out_free);
    assign o_raddr = r_ptr;
    assign o_busy  = (r_left != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_run.start) begin
                r_left <= i_run.count;
            end else if (o_re) begin
                r_left <= r_left - psfp_pkg::IDX_W'(1);
            end
            if (o_re) begin
                r_rd_vld <= 1'b1;
            end else if (w_out_free) begin
                r_rd_vld <= 1'b0;
            end
            if (w_out_free) begin
                r_out_vld <= r_rd_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run.start) begin
            r_ptr <= psfp_pkg::ADDR_W'(psfp_pkg::PAYLOAD_BASE);
            r_k   <= '0;
        end else if (o_re) begin
            r_ptr <= r_ptr + psfp_pkg::ADDR_W'(1);
            r_k   <= r_k + psfp_pkg::IDX_W'(1);
        end
        if (o_re) begin
            r_rd_idx  <= r_k;
            r_rd_last <= (r_left == psfp_pkg::IDX_W'(1));
        end
        if (w_out_free && r_rd_vld) begin
            r_out_byte <= i_rdata;
            r_out_idx  <= r_rd_idx;
            r_out_last <= r_rd_last;
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_tdata  = {2'b00, r_out_idx, r_out_byte};
    assign o_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/preamble_sum_frame_parser.sv @@
`default_nettype none

// Frame parser for a received byte stream: three configurable sync bytes, a
// payload and an additive checksum byte, with the total frame length set by
// register frame_length (index 3); indexes 0 to 2 hold the sync byte values.
// Bytes enter on the s_axis channel, one per transaction. Payload bytes are
// kept in a 64-entry frame store and summed modulo 256 as they arrive.
// When the checksum byte matches, the payload is replayed on m_axis as one
// run: tdata carries the byte and its index, tlast marks the final byte.
// A bad checksum or an overlong frame gives no output.
// After a matching checksum byte the run count is loaded, then each payload
// byte is read from the store into the read-data register and moved on to
// the output register, one byte per cycle while the receiver takes them; the
// store's single read port sets that rate. Input is held off (s_axis_tready
// low) until every payload byte has been read from the store, and longer if
// m_axis stalls. A stall holds the output and read-data registers.
// Synchronous reset returns the parser to the hunt for the first sync byte,
// drops any run in progress and sets the registers to their defaults.
module preamble_sum_frame_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [7:0] payload_byte, [13:8] payload_index
    output logic             o_m_axis_tlast
);

    psfp_pkg::t_store_wr         w_wr;
    psfp_pkg::t_run              w_run;
    logic                        w_re;
    logic [psfp_pkg::ADDR_W-1:0] w_raddr;
    logic [7:0]                  w_rdata;
    logic                        w_busy;
    logic                        w_accept;

    assign o_s_axis_tready = !w_busy;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    psfp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_byte     (i_s_axis_tdata),
        .o_wr       (w_wr),
        .o_run      (w_run)
    );

    psfp_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    psfp_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_run    (w_run),
        .o_re     (w_re),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata),
        .o_busy   (w_busy),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr.we && w_re))
        else $error("frame store written and read in the same cycle");

    a_run_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_run.start |-> !w_busy)
        else $error("payload run started while a run is still being read");

    a_run_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_run.start |-> (w_run.count != '0))
        else $error("payload run started with no bytes");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_run.start |=> w_busy)
        else $error("input not held off after a payload run started");
`endif

endmodule

`default_nettype wire

@@ sim/psfp_checker.sv @@
`default_nettype none

module psfp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_rx_valid,
    input  wire logic        i_rx_ready,
    input  wire logic [7:0]  i_rx_data,    // [7:0] rx_byte
    input  wire logic        i_pl_valid,
    input  wire logic        i_pl_ready,
    input  wire logic [15:0] i_pl_data,    // [7:0] payload_byte, [13:8] payload_index
    input  wire logic        i_pl_last,
    output int               o_fail_count,
    output int               o_pending
);

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        HUNT_THIRD,
        TAKE_PAYLOAD,
        CHECK_SUM
    } t_parse_phase;

    typedef struct packed {
        logic [7:0]                 data;
        logic [psfp_pkg::IDX_W-1:0] index;
        logic                       last;
    } t_payload_beat;

    logic [7:0]    sync_first;
    logic [7:0]    sync_second;
    logic [7:0]    sync_third;
    logic [6:0]    frame_len;
    t_parse_phase  phase;
    logic [6:0]    wr_pos;
    logic [7:0]    payload_sum;
    logic [6:0]    held_len;
    logic [7:0]    frame_bytes [psfp_pkg::STORE_LIMIT];
    t_payload_beat payload_q [$];
    int            fails = 0;

    // Advances the parser by one received byte and queues the payload of any
    // frame whose checksum matches.
    task automatic parse_byte(input logic [7:0] b);
        int            n;
        t_payload_beat beat;
        case (phase)
            HUNT_SECOND: begin
                if (b == sync_second) begin
                    wr_pos      = 7'd1;
                    held_len    = frame_len;
                    payload_sum = '0;
                    phase       = HUNT_THIRD;
                end else begin
                    phase = HUNT_FIRST;
                end
            end
            HUNT_THIRD: begin
                if (b == sync_third) begin
                    wr_pos      = 7'(psfp_pkg::PAYLOAD_BASE);
                    held_len    = frame_len;
                    payload_sum = '0;
                    phase       = TAKE_PAYLOAD;
                end else begin
                    phase = HUNT_FIRST;
                end
            end
            TAKE_PAYLOAD: begin
                // A full store drops the byte and abandons the frame.
                if (int'(wr_pos) >= psfp_pkg::STORE_LIMIT - 1) begin
                    phase = HUNT_FIRST;
                end else begin
                    frame_bytes[wr_pos[psfp_pkg::ADDR_W-1:0]] = b;
                    wr_pos      = wr_pos + 7'd1;
                    payload_sum = payload_sum + b;
                    if (int'(wr_pos) + 1 >= int'(held_len)) begin
                        phase = CHECK_SUM;
                    end
                end
            end
            CHECK_SUM: begin
                if (b == payload_sum && int'(wr_pos) > psfp_pkg::PAYLOAD_BASE) begin
                    n = int'(wr_pos) - psfp_pkg::PAYLOAD_BASE;
                    for (int k = 0; k < n; k++) begin
                        beat.data  = frame_bytes[psfp_pkg::PAYLOAD_BASE + k];
                        beat.index = psfp_pkg::IDX_W'(k);
                        beat.last  = (k == n - 1);
                        payload_q.push_back(beat);
                    end
                end
                phase = HUNT_FIRST;
            end
            default: begin
                wr_pos      = '0;
                payload_sum = '0;
                phase       = (b == sync_first) ? HUNT_SECOND : HUNT_FIRST;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_payload_beat want;
        if (!i_rst_n) begin
            sync_first  = '0;
            sync_second = '0;
            sync_third  = '0;
            frame_len   = 7'd16;
            phase       = HUNT_FIRST;
            wr_pos      = '0;
            payload_sum = '0;
            held_len    = '0;
            payload_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (psfp_pkg::t_cfg_idx'(i_cfg_idx))
                    psfp_pkg::CFG_SYNC_FIRST:  sync_first  = i_cfg_data;
                    psfp_pkg::CFG_SYNC_SECOND: sync_second = i_cfg_data;
                    psfp_pkg::CFG_SYNC_THIRD:  sync_third  = i_cfg_data;
                    psfp_pkg::CFG_FRAME_LEN:   frame_len   = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_rx_valid && i_rx_ready) begin
                parse_byte(i_rx_data);
            end
            if (i_pl_valid && i_pl_ready) begin
                if (payload_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected payload transaction: expected none, %s",
                             $time, $sformatf("got %04h last %0b", i_pl_data, i_pl_last));
                end else begin
                    want = payload_q.pop_front();
                    if (i_pl_data[7:0] != want.data) begin
                        fails++;
                        $display("%0t: payload_byte: expected %02h, got %02h",
                                 $time, want.data, i_pl_data[7:0]);
                    end
                    if (i_pl_data[13:8] != want.index) begin
                        fails++;
                        $display("%0t: payload_index: expected %0d, got %0d",
                                 $time, want.index, i_pl_data[13:8]);
                    end
                    if (i_pl_last != want.last) begin
                        fails++;
                        $display("%0t: last_of_frame: expected %0b, got %0b",
                                 $time, want.last, i_pl_last);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= payload_q.size();
    end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef enum {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_SECOND,
        FR_BAD_THIRD,
        FR_NOISE
    } t_frame_kind;

    localparam logic [7:0] EDGE_BYTES [6] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_idx  = '0;
    logic [7:0]  cfg_data = '0;
    logic        rx_valid = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_data  = '0;
    logic        pl_valid;
    logic        pl_ready = 1'b0;
    logic [15:0] pl_data;
    logic        pl_last;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_req = 1'b0;
    int          hold_left = 0;

    // Settings in force, kept here to build frames that match them.
    logic [7:0]  sync1 = 8'h00;
    logic [7:0]  sync2 = 8'h00;
    logic [7:0]  sync3 = 8'h00;
    logic [6:0]  frame_len = 7'd16;

    preamble_sum_frame_parser dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (rx_valid),
        .o_s_axis_tready (rx_ready),
        .i_s_axis_tdata  (rx_data),
        .o_m_axis_tvalid (pl_valid),
        .i_m_axis_tready (pl_ready),
        .o_m_axis_tdata  (pl_data),
        .o_m_axis_tlast  (pl_last)
    );

    psfp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_rx_valid   (rx_valid),
        .i_rx_ready   (rx_ready),
        .i_rx_data    (rx_data),
        .i_pl_valid   (pl_valid),
        .i_pl_ready   (pl_ready),
        .i_pl_data    (pl_data),
        .i_pl_last    (pl_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The long hold-off is timed here, apart from the random stalls.
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin
        if (hold_left != 0) begin
            pl_ready <= 1'b0;
        end else begin
            pl_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= b;
        do @(posedge clk); while (!rx_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_frame_kind kind, input bit edge_values);
        logic [7:0] sum;
        logic [7:0] b;
        int         n;
        sum = '0;
        // Overlong frames run until the store is full and one byte is dropped.
        n = (frame_len > 7'd64) ? 61 : (frame_len < 7'd5) ? 1 : int'(frame_len) - 4;
        case (kind)
            FR_NOISE: begin
                b = 8'($urandom_range(0, 255));
                if (b == sync1) begin
                    b = ~b;
                end
                send_byte(b);
            end
            FR_BAD_SECOND: begin
                send_byte(sync1);
                send_byte(sync2 ^ 8'($urandom_range(1, 255)));
            end
            FR_BAD_THIRD: begin
                send_byte(sync1);
                send_byte(sync2);
                send_byte(sync3 ^ 8'($urandom_range(1, 255)));
            end
            default: begin
                send_byte(sync1);
                send_byte(sync2);
                send_byte(sync3);
                for (int k = 0; k < n; k++) begin
                    b = edge_values ? EDGE_BYTES[k % 6] : 8'($urandom_range(0, 255));
                    sum += b;
                    send_byte(b);
                end
                if (frame_len <= 7'd64) begin
                    send_byte((kind == FR_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
                end
            end
        endcase
    endtask

    // Waits until every queued payload byte has come out, then a little longer.
    task automatic settle();
        rx_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] s3, input logic [6:0] len);
        cfg_we   <= 1'b1;
        cfg_idx  <= psfp_pkg::CFG_SYNC_FIRST;
        cfg_data <= s1;
        @(posedge clk);
        cfg_idx  <= psfp_pkg::CFG_SYNC_SECOND;
        cfg_data <= s2;
        @(posedge clk);
        cfg_idx  <= psfp_pkg::CFG_SYNC_THIRD;
        cfg_data <= s3;
        @(posedge clk);
        cfg_idx  <= psfp_pkg::CFG_FRAME_LEN;
        cfg_data <= {1'b0, len};
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
        sync1     = s1;
        sync2     = s2;
        sync3     = s3;
        frame_len = len;
    endtask

    task automatic run_phase(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] s3, input logic [6:0] len,
                             input int idle, input int stall, input int budget,
                             input bit hold_off);
        int          start;
        int          r;
        t_frame_kind kind;
        set_config(s1, s2, s3, len);
        send_idle_pct = idle;
        stall_pct    <= stall;
        if (hold_off) begin
            hold_req <= 1'b1;
            @(posedge clk);
            hold_req <= 1'b0;
        end
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            r = $urandom_range(0, 99);
            kind = (r < 70) ? FR_GOOD : (r < 80) ? FR_BAD_SUM : (r < 87) ? FR_BAD_SECOND :
                   (r < 94) ? FR_BAD_THIRD : FR_NOISE;
            send_frame(kind, 1'b0);
        end
        settle();
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a frame under the reset settings, then a one-byte frame and the sync failures under new settings.
        send_frame(FR_GOOD, 1'b1);
        settle();
        set_config(8'hA5, 8'h5A, 8'hC3, 7'd5);
        send_frame(FR_GOOD, 1'b1);
        send_frame(FR_BAD_SECOND, 1'b0);
        send_frame(FR_BAD_THIRD, 1'b0);
        settle();

        run_phase(8'h3C, 8'hC3, 8'h96, 7'd5, 0, 0, 25, 1'b0);
        // Lengths below five still carry a single payload byte.
        run_phase(8'hFF, 8'h00, 8'hFF, 7'd4, 48, 0, 20, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 7'd16, 0, 48, 32, 1'b1);
        run_phase(8'h00, 8'hFF, 8'h00, 7'd64, 25, 25, 40, 1'b0);
        run_phase(8'hFF, 8'hFF, 8'hFF, 7'd100, 25, 25, 40, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 7'd9, 0, 0, 20, 1'b0);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
